/* hw/rtl/pss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Types, opcodes and the note stream ROM shared by the sound sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 2;

    localparam int STREAM_W = 3;
    localparam int POS_W    = 3;
    localparam int PRIO_W   = 8;
    localparam int WORD_W   = 16;

    localparam logic [STREAM_W-1:0] STREAM_DEFAULT = 3'd4;

    localparam logic [WORD_W-1:0] OFFSET_S0 = 16'h00DB;
    localparam logic [WORD_W-1:0] OFFSET_S1 = 16'h965E;
    localparam logic [WORD_W-1:0] OFFSET_S2 = 16'h9676;
    localparam logic [WORD_W-1:0] OFFSET_S3 = 16'h96B6;

    // raw mode codes on the input port
    typedef enum logic [2:0] {
        MODE_GATE_ON  = 3'd0,
        MODE_PLAY     = 3'd1,
        MODE_GATE_OFF = 3'd2,
        MODE_STOP     = 3'd3,
        MODE_QUERY    = 3'd4,
        MODE_TICK     = 3'd5
    } t_mode;

    // decoded operation carried to the back end
    typedef enum logic [2:0] {
        OP_QUERY,
        OP_GATE_ON,
        OP_PLAY,
        OP_GATE_OFF,
        OP_STOP,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [STREAM_W-1:0] stream;
        logic [PRIO_W-1:0]   prio;
    } t_cmd;

    typedef struct packed {
        logic                playing;
        logic [PRIO_W-1:0]   prio;
        logic [WORD_W-1:0]   ticks_left;
        logic [POS_W-1:0]    position;
        logic [STREAM_W-1:0] stream;
    } t_result;

    function automatic logic [STREAM_W-1:0] lookup_stream(input logic [WORD_W-1:0] offset);
        logic [STREAM_W-1:0] sel;
        case (offset)
            OFFSET_S0: sel = 3'd0;
            OFFSET_S1: sel = 3'd1;
            OFFSET_S2: sel = 3'd2;
            OFFSET_S3: sel = 3'd3;
            default:   sel = STREAM_DEFAULT;
        endcase
        return sel;
    endfunction

    // number of words in each stream
    function automatic logic [POS_W:0] stream_length(input logic [STREAM_W-1:0] sel);
        logic [POS_W:0] len;
        case (sel)
            3'd0, 3'd1, 3'd2, 3'd3: len = 4'd6;
            default:                len = 4'd4;
        endcase
        return len;
    endfunction

    function automatic logic [WORD_W-1:0] rom_word(input logic [STREAM_W-1:0] sel,
                                                  input logic [POS_W-1:0]    idx);
        logic [WORD_W-1:0] w;
        w = '0;
        case (sel)
            3'd0: begin
                case (idx)
                    3'd0: w = 16'h0300;
                    3'd1: w = 16'h0004;
                    3'd2: w = 16'h0280;
                    3'd3: w = 16'h0003;
                    default: w = '0;
                endcase
            end
            3'd1: begin
                case (idx)
                    3'd0: w = 16'h0200;
                    3'd1: w = 16'h0006;
                    3'd2: w = 16'h0100;
                    3'd3: w = 16'h0004;
                    default: w = '0;
                endcase
            end
            3'd2: begin
                case (idx)
                    3'd0: w = 16'h0180;
                    3'd1: w = 16'h0002;
                    3'd2: w = 16'h0200;
                    3'd3: w = 16'h0002;
                    default: w = '0;
                endcase
            end
            3'd3: begin
                case (idx)
                    3'd0: w = 16'h0250;
                    3'd1: w = 16'h0004;
                    3'd2: w = 16'h01F0;
                    3'd3: w = 16'h0003;
                    default: w = '0;
                endcase
            end
            default: begin
                case (idx)
                    3'd0: w = 16'h01C0;
                    3'd1: w = 16'h0003;
                    default: w = '0;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/priority_sound_sequencer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_sound_sequencer_unit
// Priority sound sequencer: play/stop/gate commands and note ticks.
// ----------------------------------------------------------------------------
// Every item (gate on, play, gate off, stop, query or tick) returns one item
// with the state after that update. Sustained rate is one item per cycle while
// the result queue is not full: the back end computes the next sequencer state
// combinationally and registers it. An item passes the input register, then
// the command queue, then the result queue, which shows it as soon as it is
// written. The command queue decouples the decode from the state update and
// the result queue lets pop stall freely.
// ----------------------------------------------------------------------------
module priority_sound_sequencer_unit #(
    parameter int CMD_DEPTH = pss_pkg::CMD_Q_DEPTH,
    parameter int RES_DEPTH = pss_pkg::RES_Q_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [2:0]                 i_mode,
    input  wire logic [pss_pkg::WORD_W-1:0] i_sound_addr,
    input  wire logic [pss_pkg::PRIO_W-1:0] i_request_priority,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_playing,
    output logic [pss_pkg::PRIO_W-1:0]      o_current_priority,
    output logic [pss_pkg::WORD_W-1:0]      o_ticks_left,
    output logic [pss_pkg::POS_W-1:0]       o_word_position,
    output logic [pss_pkg::STREAM_W-1:0]    o_stream_id
);
    import pss_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    logic    fe_valid;
    t_cmd    fe_cmd;
    logic    cq_full, cq_empty;
    t_cmd    cq_cmd;
    logic    be_pop, be_push;
    t_result be_result;
    logic    rq_full;
    t_result rq_result;

    pss_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_mode             (i_mode),
        .i_sound_addr       (i_sound_addr),
        .i_request_priority (i_request_priority),
        .o_valid            (fe_valid),
        .o_cmd              (fe_cmd),
        .i_q_full           (cq_full)
    );

    pss_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_data  (fe_cmd),
        .o_full  (cq_full),
        .i_pop   (be_pop),
        .o_data  (cq_cmd),
        .o_empty (cq_empty)
    );

    pss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!cq_empty),
        .i_cmd    (cq_cmd),
        .o_pop    (be_pop),
        .o_push   (be_push),
        .o_result (be_result),
        .i_full   (rq_full)
    );

    pss_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push),
        .i_data  (be_result),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_result),
        .o_empty (empty)
    );

    assign o_playing          = rq_result.playing;
    assign o_current_priority = rq_result.prio;
    assign o_ticks_left       = rq_result.ticks_left;
    assign o_word_position    = rq_result.position;
    assign o_stream_id        = rq_result.stream;

endmodule
`default_nettype wire

/* hw/rtl/pss_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pss_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_front
// Accepts items, decodes the mode and maps the stream offset to a stream id.
// ----------------------------------------------------------------------------
module pss_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [2:0]                 i_mode,
    input  wire logic [pss_pkg::WORD_W-1:0] i_sound_addr,
    input  wire logic [pss_pkg::PRIO_W-1:0] i_request_priority,
    output logic                            o_valid,
    output pss_pkg::t_cmd                   o_cmd,
    input  wire logic                       i_q_full
);
    import pss_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept;

    assign o_full  = r_valid && i_q_full;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = accept || (r_valid && i_q_full);
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.prio   = i_request_priority;
            n_cmd.stream = lookup_stream(i_sound_addr);
            case (i_mode)
                MODE_GATE_ON:  n_cmd.op = OP_GATE_ON;
                MODE_PLAY:     n_cmd.op = OP_PLAY;
                MODE_GATE_OFF: n_cmd.op = OP_GATE_OFF;
                MODE_STOP:     n_cmd.op = OP_STOP;
                MODE_TICK:     n_cmd.op = OP_TICK;
                default:       n_cmd.op = OP_QUERY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

/* hw/rtl/pss_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pss_back
// Keeps sequencer state; one item per cycle unless the result queue is full.
// ----------------------------------------------------------------------------
module pss_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pss_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_push,
    output pss_pkg::t_result   o_result,
    input  wire logic          i_full
);
    import pss_pkg::*;

    logic                r_play, n_play;
    logic                r_enable, n_enable;
    logic [PRIO_W-1:0]   r_prio, n_prio;
    logic [STREAM_W-1:0] r_stream, n_stream;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [WORD_W-1:0]   r_count, n_count;

    logic              go;
    logic [POS_W:0]    pos_next_word;
    logic [WORD_W-1:0] divisor, duration;

    assign go     = i_valid && !i_full;
    assign o_pop  = go;
    assign o_push = go;

    assign pos_next_word = {1'b0, r_pos} + 1'b1;
    assign divisor       = rom_word(r_stream, r_pos);
    assign duration      = rom_word(r_stream, pos_next_word[POS_W-1:0]);

    always_comb begin
        n_play   = r_play;
        n_enable = r_enable;
        n_prio   = r_prio;
        n_stream = r_stream;
        n_pos    = r_pos;
        n_count  = r_count;
        if (go) begin
            case (i_cmd.op)
                OP_GATE_ON: begin
                    n_enable = 1'b1;
                end
                OP_GATE_OFF: begin
                    n_enable = 1'b0;
                end
                OP_PLAY: begin
                    if (!r_play || i_cmd.prio >= r_prio) begin
                        n_play   = 1'b1;
                        n_enable = 1'b1;
                        n_prio   = i_cmd.prio;
                        n_stream = i_cmd.stream;
                        n_pos    = '0;
                        n_count  = '0;
                    end
                end
                OP_STOP: begin
                    n_play  = 1'b0;
                    n_pos   = '0;
                    n_count = '0;
                end
                OP_TICK: begin
                    if (r_play && r_enable) begin
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end else if (pos_next_word >= stream_length(r_stream)) begin
                            // end of stream, position is kept
                            n_play  = 1'b0;
                            n_count = '0;
                        end else begin
                            n_pos = r_pos + POS_W'(2);
                            if (divisor == '0) begin
                                n_play  = 1'b0;
                                n_count = '0;
                            end else begin
                                n_count = (duration == '0) ? WORD_W'(1) : duration;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play   <= 1'b0;
            r_enable <= 1'b0;
            r_prio   <= '0;
            r_stream <= STREAM_DEFAULT;
            r_pos    <= '0;
            r_count  <= '0;
        end else begin
            r_play   <= n_play;
            r_enable <= n_enable;
            r_prio   <= n_prio;
            r_stream <= n_stream;
            r_pos    <= n_pos;
            r_count  <= n_count;
        end
    end

    always_comb begin
        o_result.playing    = n_play && n_enable;
        o_result.prio       = n_prio;
        o_result.ticks_left = n_count;
        o_result.position   = n_pos;
        o_result.stream     = n_stream;
    end

endmodule
`default_nettype wire

/* bench/sequencer_status_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequencer_status_checker
// Watches both queue ports of the sound sequencer, keeps its own model of the
// play state, predicts the status item for every accepted command or tick,
// and compares each popped item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sequencer_status_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_sound_addr,
    input  wire logic [7:0]  i_request_priority,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic        i_playing,
    input  wire logic [7:0]  i_current_priority,
    input  wire logic [15:0] i_ticks_left,
    input  wire logic [2:0]  i_word_position,
    input  wire logic [2:0]  i_stream_id,
    output int               o_error_count,
    output int               o_pending
);
    import pss_pkg::*;

    localparam int MAX_PRINTED = 40;

    // first four words of each stream, {stream 4 .. stream 0}, {w3 .. w0}
    localparam logic [4:0][3:0][15:0] NOTE_ROM = {
        {16'h0000, 16'h0000, 16'h0003, 16'h01C0},
        {16'h0003, 16'h01F0, 16'h0004, 16'h0250},
        {16'h0002, 16'h0200, 16'h0002, 16'h0180},
        {16'h0004, 16'h0100, 16'h0006, 16'h0200},
        {16'h0003, 16'h0280, 16'h0004, 16'h0300}
    };

    logic        seq_playing;
    logic        seq_enabled;
    logic [7:0]  seq_priority;
    logic [2:0]  seq_stream;
    logic [2:0]  seq_position;
    logic [15:0] seq_countdown;

    t_result expected_status[$];
    t_result oldest;

    initial o_error_count = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_error_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_error_count++;
    endtask

    function automatic logic [15:0] note_word(input logic [2:0] sel, input int idx);
        if (idx > 3 || sel > STREAM_DEFAULT)
            return 16'h0000;
        return NOTE_ROM[sel][idx];
    endfunction

    function automatic logic [2:0] stream_of(input logic [15:0] offset);
        if (offset == OFFSET_S0) return 3'd0;
        if (offset == OFFSET_S1) return 3'd1;
        if (offset == OFFSET_S2) return 3'd2;
        if (offset == OFFSET_S3) return 3'd3;
        return STREAM_DEFAULT;
    endfunction

    task automatic advance_note();
        logic [15:0] divisor;
        logic [15:0] duration;
        int          words;
        if (!seq_playing || !seq_enabled)
            return;
        if (seq_countdown != 16'd0) begin
            seq_countdown = seq_countdown - 16'd1;
            return;
        end
        words = (seq_stream < STREAM_DEFAULT) ? 6 : 4;
        // no full pair left in the stream
        if (int'(seq_position) + 1 >= words) begin
            seq_playing   = 1'b0;
            seq_countdown = 16'd0;
            return;
        end
        divisor      = note_word(seq_stream, int'(seq_position));
        duration     = note_word(seq_stream, int'(seq_position) + 1);
        seq_position = seq_position + 3'd2;
        if (divisor == 16'd0) begin
            seq_playing   = 1'b0;
            seq_countdown = 16'd0;
        end else begin
            seq_countdown = (duration == 16'd0) ? 16'd1 : duration;
        end
    endtask

    task automatic apply_item(input logic [2:0] mode, input logic [15:0] offset,
                              input logic [7:0] prio);
        t_result status;
        case (mode)
            MODE_GATE_ON:  seq_enabled = 1'b1;
            MODE_PLAY: begin
                if (!seq_playing || prio >= seq_priority) begin
                    seq_playing   = 1'b1;
                    seq_enabled   = 1'b1;
                    seq_priority  = prio;
                    seq_stream    = stream_of(offset);
                    seq_countdown = 16'd0;
                    seq_position  = 3'd0;
                end
            end
            MODE_GATE_OFF: seq_enabled = 1'b0;
            MODE_STOP: begin
                seq_playing   = 1'b0;
                seq_countdown = 16'd0;
                seq_position  = 3'd0;
            end
            MODE_TICK:     advance_note();
            default: ;  // query and the spare codes leave the state alone
        endcase
        status.playing    = seq_playing & seq_enabled;
        status.prio       = seq_priority;
        status.ticks_left = seq_countdown;
        status.position   = seq_position;
        status.stream     = seq_stream;
        expected_status.insert(expected_status.size(), status);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_playing   = 1'b0;
            seq_enabled   = 1'b0;
            seq_priority  = 8'd0;
            seq_stream    = STREAM_DEFAULT;
            seq_position  = 3'd0;
            seq_countdown = 16'd0;
            expected_status.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("item with nothing expected", i_ticks_left, 16'h0000);
                end else begin
                    oldest = expected_status.pop_front();
                    if (i_playing !== oldest.playing)
                        report_mismatch("playing", 16'(i_playing), 16'(oldest.playing));
                    if (i_current_priority !== oldest.prio)
                        report_mismatch("current_priority", 16'(i_current_priority),
                                        16'(oldest.prio));
                    if (i_ticks_left !== oldest.ticks_left)
                        report_mismatch("ticks_left", i_ticks_left, oldest.ticks_left);
                    if (i_word_position !== oldest.position)
                        report_mismatch("word_position", 16'(i_word_position),
                                        16'(oldest.position));
                    if (i_stream_id !== oldest.stream)
                        report_mismatch("stream_id", 16'(i_stream_id), 16'(oldest.stream));
                end
            end
            if (i_push && !i_full)
                apply_item(i_mode, i_sound_addr, i_request_priority);
        end
        o_pending = expected_status.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and ticks into the sound sequencer with random gaps on both
// queue ports: a directed opening, then random play sequences mixed with
// noise. A long pop hold-off fills the block and a drain empties it. The
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
    import pss_pkg::*;

    localparam int          ITEM_TARGET    = 600;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_HOLD      = 150;
    localparam logic [2:0]  MODE_SPARE_6   = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7   = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  mode;
    logic [15:0] sound_addr;
    logic [7:0]  request_priority;
    logic        empty;
    logic        pop;
    logic        playing;
    logic [7:0]  current_priority;
    logic [15:0] ticks_left;
    logic [2:0]  word_position;
    logic [2:0]  stream_id;
    int          error_count;
    int          pending;
    int          items_sent = 0;
    int          idle_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    priority_sound_sequencer_unit u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .push               (push),
        .full               (full),
        .i_mode             (mode),
        .i_sound_addr       (sound_addr),
        .i_request_priority (request_priority),
        .empty              (empty),
        .pop                (pop),
        .o_playing          (playing),
        .o_current_priority (current_priority),
        .o_ticks_left       (ticks_left),
        .o_word_position    (word_position),
        .o_stream_id        (stream_id)
    );

    sequencer_status_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_mode             (mode),
        .i_sound_addr       (sound_addr),
        .i_request_priority (request_priority),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_playing          (playing),
        .i_current_priority (current_priority),
        .i_ticks_left       (ticks_left),
        .i_word_position    (word_position),
        .i_stream_id        (stream_id),
        .o_error_count      (error_count),
        .o_pending          (pending)
    );

    // no item moved on either port for too long
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    int send_burst_left = 0;

    task automatic send_item(input logic [2:0] m, input logic [15:0] offset,
                             input logic [7:0] prio);
        int gap;
        if (send_burst_left > 0) begin
            gap = 0;
            send_burst_left--;
        end else begin
            if ($urandom_range(0, 31) == 0)
                send_burst_left = 20;
            gap = $urandom_range(0, 7);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push             <= 1'b1;
        mode             <= m;
        sound_addr       <= offset;
        request_priority <= prio;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return OFFSET_S0;
            1: return OFFSET_S1;
            2: return OFFSET_S2;
            3: return OFFSET_S3;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // a play request then mostly ticks, with the odd gate, query, stop or rival play
    task automatic play_sequence();
        int n;
        if ($urandom_range(0, 3) == 0)
            send_item(MODE_GATE_ON, 16'($urandom), 8'($urandom));
        send_item(MODE_PLAY, pick_offset(), 8'($urandom_range(0, 255)));
        n = $urandom_range(4, 24);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0: send_item(MODE_GATE_OFF, 16'($urandom), 8'($urandom));
                1: send_item(MODE_GATE_ON, 16'($urandom), 8'($urandom));
                2: send_item(MODE_QUERY, 16'($urandom), 8'($urandom));
                3: send_item(MODE_PLAY, pick_offset(), 8'($urandom_range(0, 255)));
                4: send_item(MODE_STOP, 16'($urandom), 8'($urandom));
                default: send_item(MODE_TICK, 16'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin : result_side
        int gap;
        int quiet_left;
        int popped;
        quiet_left = 0;
        popped     = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (popped == 150 || popped == 450) begin
                gap = LONG_HOLD;
            end else if (quiet_left > 0) begin
                gap = 0;
                quiet_left--;
            end else begin
                if ($urandom_range(0, 31) == 0)
                    quiet_left = 16;
                gap = $urandom_range(0, 7);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            popped++;
        end
    end

    initial begin : command_side
        bit drained;
        drained          = 1'b0;
        rst_n            <= 1'b0;
        push             <= 1'b0;
        mode             <= MODE_QUERY;
        sound_addr       <= 16'h0000;
        request_priority <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        send_item(MODE_QUERY, 16'hFFFF, 8'hFF);
        send_item(MODE_TICK, 16'h0000, 8'h00);      // tick while idle
        send_item(MODE_SPARE_6, 16'hFFFF, 8'hFF);
        send_item(MODE_SPARE_7, 16'h0000, 8'h00);
        send_item(MODE_PLAY, 16'hFFFF, 8'h80);      // default stream
        send_item(MODE_TICK, 16'h0000, 8'h00);
        send_item(MODE_PLAY, OFFSET_S0, 8'h7F);     // lower priority, refused
        send_item(MODE_GATE_OFF, 16'h0000, 8'h00);
        send_item(MODE_TICK, 16'h0000, 8'h00);      // gated off, no change
        send_item(MODE_GATE_ON, 16'h0000, 8'h00);
        repeat (5) send_item(MODE_TICK, 16'h0000, 8'h00);  // runs into zero divisor
        send_item(MODE_STOP, 16'h0000, 8'h00);
        send_item(MODE_PLAY, OFFSET_S1, 8'h00);
        send_item(MODE_PLAY, OFFSET_S2, 8'h00);     // equal priority replaces
        send_item(MODE_PLAY, OFFSET_S3, 8'hFF);
        send_item(MODE_PLAY, OFFSET_S0, 8'hFF);
        send_item(MODE_TICK, 16'hFFFF, 8'hFF);
        send_item(MODE_STOP, 16'hFFFF, 8'hFF);
        send_item(MODE_GATE_OFF, 16'hFFFF, 8'hFF);
        send_item(MODE_PLAY, 16'h0000, 8'h55);      // play re-enables the gate
        send_item(MODE_QUERY, 16'h0000, 8'h00);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) == 0)
                send_item(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
            else
                play_sequence();
            if (!drained && items_sent >= ITEM_TARGET / 2) begin
                wait_all_results();
                drained = 1'b1;
            end
        end

        wait_all_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
